[hw/rtl/bdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  // Result status codes carried in the output tuser field.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam int unsigned WORD_W = 32;

  // Per-item result flags handed from the pointer control to the output stages.
  typedef struct packed {
    status_t status;
    logic    pop_ok;
    logic    is_empty;
    logic    is_full;
  } res_flags_t;

endpackage

`default_nettype wire

[hw/rtl/bdq_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic                       re,
  input  wire logic [IW-1:0]              addr,
  input  wire logic [bdq_pkg::WORD_W-1:0] wdata,
  output logic      [bdq_pkg::WORD_W-1:0] rdata
);

  logic [bdq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bdq_pkg::WORD_W-1:0] rdata_r;

  // Single port; read data is registered, appears in the cycle after the read and holds until the next.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/bdq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4,
  parameter int unsigned CW    = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [1:0]          op,
  output logic                     mem_we,
  output logic                     mem_re,
  output logic [IW-1:0]            mem_addr,
  output bdq_pkg::res_flags_t      flags,
  output logic [CW-1:0]            occ
);

  localparam int unsigned SW = CW + 1;

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          is_full_now, is_empty_now;
  logic [SW-1:0] rear_sum, rear_pos;
  logic [SW-1:0] last_sum, last_pos;
  logic [IW-1:0] head_dec, head_inc;

  assign is_full_now  = (count_r >= CW'(DEPTH));
  assign is_empty_now = (count_r == '0);

  // Slot past the rear and the rear slot itself; both sums stay below twice DEPTH while the deque is not empty.
  assign rear_sum = SW'(head_r) + SW'(count_r);
  assign rear_pos = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
  assign last_sum = SW'(head_r) + SW'(count_r) - SW'(1);
  assign last_pos = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;

  assign head_dec = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
  assign head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = head_r;
    flags.status   = bdq_pkg::ST_OK;
    flags.pop_ok   = 1'b0;
    unique case (bdq_pkg::op_t'(op))
      bdq_pkg::OP_PUSH_FRONT: begin
        if (is_full_now) begin
          flags.status = bdq_pkg::ST_OVERFLOW;
        end else begin
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
          mem_we    = acc;
          mem_addr  = head_dec;
        end
      end
      bdq_pkg::OP_PUSH_REAR: begin
        if (is_full_now) begin
          flags.status = bdq_pkg::ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CW'(1);
          mem_we    = acc;
          mem_addr  = IW'(rear_pos);
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (is_empty_now) begin
          flags.status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          head_nxt     = head_inc;
          count_nxt    = count_r - CW'(1);
          mem_re       = acc;
          mem_addr     = head_r;
          flags.pop_ok = 1'b1;
        end
      end
      bdq_pkg::OP_POP_REAR: begin
        if (is_empty_now) begin
          flags.status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          count_nxt    = count_r - CW'(1);
          mem_re       = acc;
          mem_addr     = IW'(last_pos);
          flags.pop_ok = 1'b1;
        end
      end
      default: begin
        flags.status = bdq_pkg::ST_OK;
      end
    endcase
    flags.is_empty = (count_nxt == '0);
    flags.is_full  = (count_nxt >= CW'(DEPTH));
    occ            = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (acc) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bounded_deque.sv]
// A result passes from its input transfer through stage 1 and the output register
// before it is offered on the output. Throughput: one operation per cycle while
// the output is not held off; each item makes at most one access to the
// single-port entry memory. A held-off output stops the input once two items wait.
// Reset (rst_n low, synchronous) empties the deque and drops any result in flight;
// the entry memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] push_value
  input  wire logic [1:0]  in_tuser,   // [1:0] op

  // Result channel.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [((34 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
      // [31:0] popped_value, [32] is_empty, [33] is_full, [34 +: occupancy width] occupancy
  output logic [1:0]                       out_tuser   // [1:0] status
);

  // Index width of the ring and width of the entry count.
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((34 + CW + 7) / 8) * 8;

  logic                        in_acc;
  logic                        mem_we;
  logic                        mem_re;
  logic [IW-1:0]               mem_addr;
  logic [31:0]                 mem_rdata;
  bdq_pkg::res_flags_t         flags;
  logic [CW-1:0]               occ;

  // Stage 1 holds the bookkeeping of an item while its memory read completes.
  logic                        s1_valid_r;
  bdq_pkg::res_flags_t         s1_flags_r;
  logic [CW-1:0]               s1_occ_r;
  logic                        s1_adv;

  // Output register parts the memory from the downstream consumer.
  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_data_r;
  logic [1:0]                  out_user_r;
  logic [31:0]                 popped;

  // Stage 1 moves on whenever the output register is empty or being drained. Since
  // stage 1 can only stall while it is full, no new read disturbs the held read data.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Pointer and count bookkeeping; also chooses the memory slot for this transfer.
  bdq_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .op       (in_tuser),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .flags    (flags),
    .occ      (occ)
  );

  // Entry storage. A push and a later pop of the same slot fall on different edges,
  // so the registered read always sees the earlier write.
  bdq_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (in_tdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r <= flags;
      s1_occ_r   <= occ;
    end
  end

  // Only a successful pop reports a word; everything else reports zero.
  assign popped = s1_flags_r.pop_ok ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The fields are zero-extended up to the whole-byte width of out_tdata.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= OUT_W'({s1_occ_r, s1_flags_r.is_full, s1_flags_r.is_empty, popped});
      out_user_r <= s1_flags_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  // A stalled stage 1 keeps its item.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_flags_r) && $stable(s1_occ_r)))
    else $error("stage 1 item changed while stalled");

  // A read is issued only for an accepted pop, never together with a write.
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we || mem_re) |-> (in_acc && !(mem_we && mem_re)))
    else $error("memory access without an accepted item, or read and write together");

  // Overflow is only reported on a full deque.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == bdq_pkg::ST_OVERFLOW) |-> out_data_r[33])
    else $error("overflow reported on a deque that is not full");

  // Underflow is only reported on an empty deque and carries no word.
  a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == bdq_pkg::ST_UNDERFLOW)
      |-> (out_data_r[32] && out_data_r[31:0] == '0))
    else $error("underflow reported on a non-empty deque or with a word");
`endif

endmodule

`default_nettype wire
